// ----- rtl/mfpc_pkg.sv -----
// Types and constants shared by the motor fader position controller.
package mfpc_pkg;

  localparam int ADC_BITS   = 10;
  localparam int MIDI_BITS  = 7;
  localparam int LEVEL_BITS = 16;
  localparam int MS_BITS    = 10;
  localparam int TIMER_BITS = 11;
  localparam int DB_BITS    = 8;
  localparam int SPEED_BITS = 8;
  localparam int DIR_BITS   = 2;

  // Serial divider sizing: dividend holds a product of an ADC value and a
  // MIDI value; every quotient the block needs fits in ADC_BITS.
  localparam int DIV_NUM_W = ADC_BITS + MIDI_BITS;
  localparam int DIV_Q_W   = ADC_BITS;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_POSITION    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_POSITION    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_ON_LEVEL  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_OFF_LEVEL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_HOLD_MS = 3'd5;

  // Register reset values.
  localparam logic [ADC_BITS-1:0]   RST_MIN_POSITION    = '0;
  localparam logic [ADC_BITS-1:0]   RST_MAX_POSITION    = '1;
  localparam logic [DB_BITS-1:0]    RST_DEADBAND        = 8'd8;
  localparam logic [LEVEL_BITS-1:0] RST_TOUCH_ON_LEVEL  = 16'd150;
  localparam logic [LEVEL_BITS-1:0] RST_TOUCH_OFF_LEVEL = 16'd50;
  localparam logic [MS_BITS-1:0]    RST_RELEASE_HOLD_MS = 10'd500;

  // Motor direction codes.
  localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_DOWN = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_UP   = 2'd2;

  // Speed rule.
  localparam logic [SPEED_BITS-1:0] SPEED_FULL  = 8'd255;
  localparam logic [SPEED_BITS-1:0] SPEED_MID   = 8'd200;
  localparam logic [SPEED_BITS-1:0] SPEED_BASE  = 8'd100;
  localparam logic [ADC_BITS-1:0]   START_NEAR  = 10'd50;
  localparam logic [ADC_BITS-1:0]   MOVE_NEAR   = 10'd100;
  localparam logic [ADC_BITS-1:0]   MOVE_MID    = 10'd150;

  localparam logic [MIDI_BITS-1:0]  MIDI_MAX    = 7'd127;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX   = 11'd2047;

  typedef struct packed {
    logic [ADC_BITS-1:0]   position_sample;
    logic [LEVEL_BITS-1:0] touch_level;
    logic [MS_BITS-1:0]    elapsed_ms;
    logic                  target_valid;
    logic [MIDI_BITS-1:0]  target_midi;
  } sample_t;

  typedef struct packed {
    logic [DIR_BITS-1:0]   motor_direction;
    logic [SPEED_BITS-1:0] motor_speed;
    logic                  is_moving;
    logic                  is_touched;
    logic [ADC_BITS-1:0]   clamped_position;
    logic [MIDI_BITS-1:0]  midi_position;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOUCH,
    ST_MUL,
    ST_TDIV,
    ST_TWAIT,
    ST_MOTOR,
    ST_MDIV,
    ST_MWAIT,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/mfpc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module mfpc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [mfpc_pkg::DIV_NUM_W-1:0]     num,
  input  logic [mfpc_pkg::ADC_BITS-1:0]      den,
  output logic [mfpc_pkg::DIV_Q_W-1:0]       quo,
  output logic                               done
);

  localparam int SH_W  = mfpc_pkg::ADC_BITS + mfpc_pkg::DIV_Q_W - 1;
  localparam int CNT_W = $clog2(mfpc_pkg::DIV_Q_W);

  logic [mfpc_pkg::DIV_NUM_W-1:0] rem;
  logic [SH_W-1:0]                den_sh;
  logic [CNT_W-1:0]               cnt;
  logic                           busy;
  logic                           fits;

  // Divisor slides right one place per step; quotient must fit DIV_Q_W bits.
  assign fits = SH_W'(rem) >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(mfpc_pkg::DIV_Q_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num;
      den_sh <= SH_W'(den) << (mfpc_pkg::DIV_Q_W - 1);
      quo    <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - mfpc_pkg::DIV_NUM_W'(den_sh);
      end
      quo    <= {quo[mfpc_pkg::DIV_Q_W-2:0], fits};
      den_sh <= den_sh >> 1;
    end
  end

endmodule

// ----- rtl/motor_fader_position_controller.sv -----
// Motorized fader position controller: touch hysteresis, clamp, mapping, motor rule.
//
// One request on the sample channel is one control tick and yields exactly one
// response on the result channel. The tick updates the touch state (on/off
// hysteresis on touch_level, motion suspended while touched and until the
// release timer passes release_hold_ms), clamps position_sample into
// [min_position, max_position], maps a new 0..127 target into that range when
// target_valid is set, then runs the deadband motor rule and reports direction,
// PWM speed, flags, the clamped position and that position as 0..127. Equal
// limits report 0; crossed limits report 127 at max and 0 at min. Every tick
// runs the touch update, motor rule and result load. A new target adds a
// 7-step serial multiply plus a 10-step division by 127, and the position-to-MIDI
// mapping adds a 10-step division whenever max_position is above min_position.
// Both divisions share one restoring divider that retires one quotient bit per
// cycle. A finished response sits in an output register, so the next request
// is taken while the previous response waits; the result load of that next
// tick holds until the output register frees up. Configuration writes are
// always accepted (cfg_ready is tied high); indexes past the register list are
// dropped. Write configuration only while the block is idle.
module motor_fader_position_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  mfpc_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output mfpc_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mfpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = mfpc_pkg::ADC_BITS;
  localparam int MW    = mfpc_pkg::MIDI_BITS;
  localparam int PW    = mfpc_pkg::DIV_NUM_W;
  localparam int MCNTW = $clog2(mfpc_pkg::MIDI_BITS);

  // Configuration registers.
  logic [AW-1:0]                        min_position;
  logic [AW-1:0]                        max_position;
  logic [mfpc_pkg::DB_BITS-1:0]         deadband;
  logic [mfpc_pkg::LEVEL_BITS-1:0]      touch_on_level;
  logic [mfpc_pkg::LEVEL_BITS-1:0]      touch_off_level;
  logic [mfpc_pkg::MS_BITS-1:0]         release_hold_ms;

  // Controller state.
  mfpc_pkg::state_t                     state, state_next;
  logic [AW-1:0]                        target_position;
  logic                                 moving;
  logic                                 touched;
  logic                                 suspended;
  logic [mfpc_pkg::TIMER_BITS-1:0]      release_timer;

  // Per-tick working registers.
  mfpc_pkg::sample_t                    req;
  mfpc_pkg::result_t                    work;
  logic [AW-1:0]                        pos;
  logic [PW-1:0]                        mul_acc;
  logic [PW-1:0]                        mul_mcand;
  logic [MW-1:0]                        mul_bits;
  logic [MCNTW-1:0]                     mul_cnt;
  logic                                 span_neg;

  // Combinational helpers.
  logic                                 touched_next;
  logic                                 suspended_next;
  logic [mfpc_pkg::TIMER_BITS-1:0]      timer_next;
  logic [mfpc_pkg::TIMER_BITS:0]        timer_sum;
  logic [AW-1:0]                        pos_clamp;
  logic [AW:0]                          span;
  logic [AW-1:0]                        span_mag;
  logic [AW-1:0]                        pos_off;
  logic [PW-1:0]                        midi_num;
  logic [AW-1:0]                        target_mapped;
  logic                                 go_down;
  logic [AW-1:0]                        err_mag;
  logic                                 drive;
  logic [mfpc_pkg::SPEED_BITS-1:0]      drive_speed;
  logic                                 load_result;

  // Divider hookup.
  logic                                 div_start;
  logic [PW-1:0]                        div_num;
  logic [AW-1:0]                        div_den;
  logic [mfpc_pkg::DIV_Q_W-1:0]         div_quo;
  logic                                 div_done;

  assign cfg_ready = 1'b1;

  mfpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Touch hysteresis and release hold.
  always_comb begin
    touched_next   = touched;
    suspended_next = suspended;
    timer_next     = release_timer;
    timer_sum      = {1'b0, release_timer} + (mfpc_pkg::TIMER_BITS+1)'(req.elapsed_ms);
    if (!touched && (req.touch_level >= touch_on_level)) begin
      touched_next   = 1'b1;
      suspended_next = 1'b1;
    end else if (touched && (req.touch_level < touch_off_level)) begin
      // Restart the hold; this tick's elapsed time is not counted.
      touched_next = 1'b0;
      timer_next   = '0;
    end else if (suspended && !touched) begin
      timer_next = timer_sum[mfpc_pkg::TIMER_BITS] ? mfpc_pkg::TIMER_MAX :
                   timer_sum[mfpc_pkg::TIMER_BITS-1:0];
    end
    if (suspended_next && !touched_next &&
        (timer_next > mfpc_pkg::TIMER_BITS'(release_hold_ms))) begin
      suspended_next = 1'b0;
    end
  end

  // Clamp into the calibrated range; with crossed limits max wins above max.
  always_comb begin
    if (req.position_sample > max_position) begin
      pos_clamp = max_position;
    end else if (req.position_sample < min_position) begin
      pos_clamp = min_position;
    end else begin
      pos_clamp = req.position_sample;
    end
  end

  // Signed span of the calibrated range and its magnitude.
  assign span     = {1'b0, max_position} - {1'b0, min_position};
  assign span_mag = span[AW] ? AW'(-span) : span[AW-1:0];

  // Position to MIDI: (pos - min) * 127, taken as (x << 7) - x.
  assign pos_off  = pos - min_position;
  assign midi_num = {pos_off, MW'(0)} - PW'(pos_off);

  // MIDI to position: min +/- |m * span| / 127, truncated toward zero.
  assign target_mapped = span_neg ? (min_position - div_quo) : (min_position + div_quo);

  // Deadband motor rule.
  assign go_down = pos > target_position;
  assign err_mag = go_down ? (pos - target_position) : (target_position - pos);
  assign drive   = !suspended && (err_mag > AW'(deadband));

  always_comb begin
    if (!moving) begin
      drive_speed = (err_mag < mfpc_pkg::START_NEAR) ? mfpc_pkg::SPEED_MID :
                                                       mfpc_pkg::SPEED_FULL;
    end else if (err_mag < mfpc_pkg::MOVE_NEAR) begin
      drive_speed = mfpc_pkg::SPEED_BASE + err_mag[mfpc_pkg::SPEED_BITS-1:0];
    end else if (err_mag < mfpc_pkg::MOVE_MID) begin
      drive_speed = mfpc_pkg::SPEED_MID;
    end else begin
      drive_speed = mfpc_pkg::SPEED_FULL;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mfpc_pkg::ST_IDLE: begin
        if (sample_valid) begin
          state_next = mfpc_pkg::ST_TOUCH;
        end
      end
      mfpc_pkg::ST_TOUCH: begin
        state_next = req.target_valid ? mfpc_pkg::ST_MUL : mfpc_pkg::ST_MOTOR;
      end
      mfpc_pkg::ST_MUL: begin
        if (mul_cnt == MCNTW'(MW - 1)) begin
          state_next = mfpc_pkg::ST_TDIV;
        end
      end
      mfpc_pkg::ST_TDIV: begin
        state_next = mfpc_pkg::ST_TWAIT;
      end
      mfpc_pkg::ST_TWAIT: begin
        if (div_done) begin
          state_next = mfpc_pkg::ST_MOTOR;
        end
      end
      mfpc_pkg::ST_MOTOR: begin
        state_next = (max_position > min_position) ? mfpc_pkg::ST_MDIV :
                                                     mfpc_pkg::ST_DONE;
      end
      mfpc_pkg::ST_MDIV: begin
        state_next = mfpc_pkg::ST_MWAIT;
      end
      mfpc_pkg::ST_MWAIT: begin
        if (div_done) begin
          state_next = mfpc_pkg::ST_DONE;
        end
      end
      mfpc_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          state_next = mfpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mfpc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    sample_ready = 1'b0;
    div_start    = 1'b0;
    div_num      = mul_acc;
    div_den      = AW'(mfpc_pkg::MIDI_MAX);
    load_result  = 1'b0;
    case (state)
      mfpc_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
      end
      mfpc_pkg::ST_TDIV: begin
        div_start = 1'b1;
      end
      mfpc_pkg::ST_MDIV: begin
        div_start = 1'b1;
        div_num   = midi_num;
        div_den   = span_mag;
      end
      mfpc_pkg::ST_DONE: begin
        load_result = !result_valid || result_ready;
      end
      default: begin
        sample_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mfpc_pkg::ST_IDLE;
      min_position    <= mfpc_pkg::RST_MIN_POSITION;
      max_position    <= mfpc_pkg::RST_MAX_POSITION;
      deadband        <= mfpc_pkg::RST_DEADBAND;
      touch_on_level  <= mfpc_pkg::RST_TOUCH_ON_LEVEL;
      touch_off_level <= mfpc_pkg::RST_TOUCH_OFF_LEVEL;
      release_hold_ms <= mfpc_pkg::RST_RELEASE_HOLD_MS;
      target_position <= '0;
      moving          <= 1'b0;
      touched         <= 1'b0;
      suspended       <= 1'b0;
      release_timer   <= '0;
      result_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          mfpc_pkg::REG_MIN_POSITION:    min_position    <= cfg_data[AW-1:0];
          mfpc_pkg::REG_MAX_POSITION:    max_position    <= cfg_data[AW-1:0];
          mfpc_pkg::REG_DEADBAND:        deadband        <= cfg_data[mfpc_pkg::DB_BITS-1:0];
          mfpc_pkg::REG_TOUCH_ON_LEVEL:  touch_on_level  <= cfg_data;
          mfpc_pkg::REG_TOUCH_OFF_LEVEL: touch_off_level <= cfg_data;
          mfpc_pkg::REG_RELEASE_HOLD_MS: release_hold_ms <= cfg_data[mfpc_pkg::MS_BITS-1:0];
          default: begin
            // Drop writes past the register list.
          end
        endcase
      end

      if (state == mfpc_pkg::ST_TOUCH) begin
        touched       <= touched_next;
        suspended     <= suspended_next;
        release_timer <= timer_next;
      end

      // A new target lands once the division by 127 finishes.
      if ((state == mfpc_pkg::ST_TWAIT) && div_done) begin
        target_position <= target_mapped;
      end

      if (state == mfpc_pkg::ST_MOTOR) begin
        if (drive) begin
          moving <= 1'b1;
        end else begin
          // Stop: snap the target to where the fader sits.
          moving          <= 1'b0;
          target_position <= pos;
        end
      end

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      mfpc_pkg::ST_IDLE: begin
        if (sample_valid) begin
          req <= sample;
        end
      end
      mfpc_pkg::ST_TOUCH: begin
        pos       <= pos_clamp;
        span_neg  <= span[AW];
        mul_acc   <= '0;
        mul_mcand <= PW'(span_mag);
        mul_bits  <= req.target_midi;
        mul_cnt   <= '0;
      end
      mfpc_pkg::ST_MUL: begin
        // Shift-add one multiplier bit per cycle, LSB first.
        if (mul_bits[0]) begin
          mul_acc <= mul_acc + mul_mcand;
        end
        mul_mcand <= mul_mcand << 1;
        mul_bits  <= mul_bits >> 1;
        mul_cnt   <= mul_cnt + 1'b1;
      end
      mfpc_pkg::ST_MOTOR: begin
        work.motor_direction  <= drive ? (go_down ? mfpc_pkg::DIR_DOWN : mfpc_pkg::DIR_UP) :
                                         mfpc_pkg::DIR_STOP;
        work.motor_speed      <= drive ? drive_speed : mfpc_pkg::SPEED_FULL;
        work.is_moving        <= drive;
        work.is_touched       <= touched;
        work.clamped_position <= pos;
        // Equal limits read 0; crossed limits read 127 only at max.
        if ((max_position < min_position) && (pos == max_position)) begin
          work.midi_position <= mfpc_pkg::MIDI_MAX;
        end else begin
          work.midi_position <= '0;
        end
      end
      mfpc_pkg::ST_MWAIT: begin
        if (div_done) begin
          work.midi_position <= div_quo[MW-1:0];
        end
      end
      mfpc_pkg::ST_DONE: begin
        if (load_result) begin
          result <= work;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

endmodule

// ----- tb/sv/motor_fader_position_controller_tb.sv -----
// Self-checking testbench for the motor fader position controller.
`timescale 1ns / 1ps

module motor_fader_position_controller_tb;

  // Tracks the fader the way the block should: touch hysteresis, release hold,
  // clamp, target mapping and the deadband motor rule. One motor command is
  // queued per accepted tick and compared against the block's results in order.
  class fader_tick_checker;
    logic [mfpc_pkg::ADC_BITS-1:0]   min_pos;
    logic [mfpc_pkg::ADC_BITS-1:0]   max_pos;
    logic [mfpc_pkg::DB_BITS-1:0]    deadband;
    logic [mfpc_pkg::LEVEL_BITS-1:0] touch_on;
    logic [mfpc_pkg::LEVEL_BITS-1:0] touch_off;
    logic [mfpc_pkg::MS_BITS-1:0]    hold_ms;
    logic [mfpc_pkg::ADC_BITS-1:0]   target_pos;
    logic                            moving;
    logic                            touched;
    logic                            suspended;
    logic [mfpc_pkg::TIMER_BITS-1:0] hold_timer;
    mfpc_pkg::result_t               motor_cmds[$];
    int                              mismatches;
    int                              checked;

    function new();
      min_pos    = mfpc_pkg::RST_MIN_POSITION;
      max_pos    = mfpc_pkg::RST_MAX_POSITION;
      deadband   = mfpc_pkg::RST_DEADBAND;
      touch_on   = mfpc_pkg::RST_TOUCH_ON_LEVEL;
      touch_off  = mfpc_pkg::RST_TOUCH_OFF_LEVEL;
      hold_ms    = mfpc_pkg::RST_RELEASE_HOLD_MS;
      target_pos = '0;
      moving     = 1'b0;
      touched    = 1'b0;
      suspended  = 1'b0;
      hold_timer = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [mfpc_pkg::CFG_INDEX_W-1:0] idx,
                          logic [mfpc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mfpc_pkg::REG_MIN_POSITION:    min_pos   = data[mfpc_pkg::ADC_BITS-1:0];
        mfpc_pkg::REG_MAX_POSITION:    max_pos   = data[mfpc_pkg::ADC_BITS-1:0];
        mfpc_pkg::REG_DEADBAND:        deadband  = data[mfpc_pkg::DB_BITS-1:0];
        mfpc_pkg::REG_TOUCH_ON_LEVEL:  touch_on  = data[mfpc_pkg::LEVEL_BITS-1:0];
        mfpc_pkg::REG_TOUCH_OFF_LEVEL: touch_off = data[mfpc_pkg::LEVEL_BITS-1:0];
        mfpc_pkg::REG_RELEASE_HOLD_MS: hold_ms   = data[mfpc_pkg::MS_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void take_tick(mfpc_pkg::sample_t s);
      mfpc_pkg::result_t             r;
      logic [mfpc_pkg::ADC_BITS-1:0] pos;
      logic [mfpc_pkg::ADC_BITS-1:0] mag;
      logic                          down;
      int                            lo;
      int                            hi;
      int                            t;
      lo = int'(min_pos);
      hi = int'(max_pos);
      r  = '0;

      // Touch: the releasing tick restarts the timer without counting its time.
      if (!touched && s.touch_level >= touch_on) begin
        touched   = 1'b1;
        suspended = 1'b1;
      end else if (touched && s.touch_level < touch_off) begin
        touched    = 1'b0;
        hold_timer = '0;
      end else if (suspended && !touched) begin
        t = int'(hold_timer) + int'(s.elapsed_ms);
        hold_timer = (t > int'(mfpc_pkg::TIMER_MAX)) ? mfpc_pkg::TIMER_MAX :
                                                       t[mfpc_pkg::TIMER_BITS-1:0];
      end
      if (suspended && !touched && hold_timer > hold_ms)
        suspended = 1'b0;

      // Clamp; with crossed limits anything not above max lands on min.
      pos = s.position_sample;
      if (pos > max_pos)
        pos = max_pos;
      else if (pos < min_pos)
        pos = min_pos;

      if (s.target_valid) begin
        t = int'(s.target_midi) * (hi - lo) / int'(mfpc_pkg::MIDI_MAX) + lo;
        target_pos = t[mfpc_pkg::ADC_BITS-1:0];
      end

      down = pos > target_pos;
      mag  = down ? pos - target_pos : target_pos - pos;

      if (!suspended && mag > deadband) begin
        if (!moving) begin
          r.motor_speed = (mag < mfpc_pkg::START_NEAR) ? mfpc_pkg::SPEED_MID :
                                                         mfpc_pkg::SPEED_FULL;
          moving = 1'b1;
        end else if (mag < mfpc_pkg::MOVE_NEAR) begin
          r.motor_speed = mfpc_pkg::SPEED_BASE + mag[mfpc_pkg::SPEED_BITS-1:0];
        end else if (mag < mfpc_pkg::MOVE_MID) begin
          r.motor_speed = mfpc_pkg::SPEED_MID;
        end else begin
          r.motor_speed = mfpc_pkg::SPEED_FULL;
        end
        r.motor_direction = down ? mfpc_pkg::DIR_DOWN : mfpc_pkg::DIR_UP;
      end else begin
        // Stop and park the target on the wiper.
        r.motor_speed     = mfpc_pkg::SPEED_FULL;
        r.motor_direction = mfpc_pkg::DIR_STOP;
        target_pos        = pos;
        moving            = 1'b0;
      end

      r.is_moving        = moving;
      r.is_touched       = touched;
      r.clamped_position = pos;
      if (lo == hi) begin
        r.midi_position = '0;
      end else begin
        t = (int'(pos) - lo) * int'(mfpc_pkg::MIDI_MAX) / (hi - lo);
        r.midi_position = t[mfpc_pkg::MIDI_BITS-1:0];
      end
      motor_cmds.push_back(r);
    endfunction

    function void check_motor_cmd(mfpc_pkg::result_t got);
      mfpc_pkg::result_t want;
      checked++;
      if (motor_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: %0t result %0d arrived with no tick outstanding", $realtime, checked);
        return;
      end
      want = motor_cmds.pop_front();
      if (got.motor_direction  !== want.motor_direction  ||
          got.motor_speed      !== want.motor_speed      ||
          got.is_moving        !== want.is_moving        ||
          got.is_touched       !== want.is_touched       ||
          got.clamped_position !== want.clamped_position ||
          got.midi_position    !== want.midi_position) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: %0t result %0d mismatch: expected dir=%0d spd=%0d mov=%0b tch=%0b pos=%0d midi=%0d",
                   $realtime, checked,
                   want.motor_direction, want.motor_speed, want.is_moving, want.is_touched,
                   want.clamped_position, want.midi_position);
          $display("tb:   got dir=%0d spd=%0d mov=%0b tch=%0b pos=%0d midi=%0d",
                   got.motor_direction, got.motor_speed, got.is_moving, got.is_touched,
                   got.clamped_position, got.midi_position);
        end
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             sample_valid;
  logic                             sample_ready;
  mfpc_pkg::sample_t                sample;
  logic                             result_valid;
  logic                             result_ready;
  mfpc_pkg::result_t                result;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [mfpc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mfpc_pkg::CFG_DATA_W-1:0]  cfg_data;

  fader_tick_checker fc;
  int gap_pct;    // chance per cycle that the tick source holds off
  int stall_pct;  // chance per cycle that the result sink stalls

  motor_fader_position_controller uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result sink: stall at random at the rate the current phase asks for.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted result; values are read before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && fc != null && result_valid && result_ready)
      fc.check_motor_cmd(result);
  end

  // Present one tick after a random hold-off, and hold it until it is taken.
  // A back-to-back tick keeps valid high and only swaps the payload.
  task automatic send_tick(input mfpc_pkg::sample_t s);
    while ($urandom_range(99) < gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    fc.take_tick(s);
  endtask

  task automatic tick(input logic [mfpc_pkg::ADC_BITS-1:0] pos,
                      input logic [mfpc_pkg::LEVEL_BITS-1:0] lvl,
                      input logic [mfpc_pkg::MS_BITS-1:0] ms, input logic tv,
                      input logic [mfpc_pkg::MIDI_BITS-1:0] m);
    mfpc_pkg::sample_t s;
    s.position_sample = pos;
    s.touch_level     = lvl;
    s.elapsed_ms      = ms;
    s.target_valid    = tv;
    s.target_midi     = m;
    send_tick(s);
  endtask

  // Drop valid and hold until every outstanding tick has produced its result.
  task automatic drain();
    sample_valid <= 1'b0;
    while (fc.motor_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mfpc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mfpc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fc.set_reg(idx, data);
  endtask

  // Reprogram every register; call only with the block idle.
  task automatic apply_setting(input int lo, input int hi, input int db,
                               input int on_lvl, input int off_lvl, input int hold);
    drain();
    repeat (40) @(posedge clk);
    write_reg(mfpc_pkg::REG_MIN_POSITION,    mfpc_pkg::CFG_DATA_W'(lo));
    write_reg(mfpc_pkg::REG_MAX_POSITION,    mfpc_pkg::CFG_DATA_W'(hi));
    write_reg(mfpc_pkg::REG_DEADBAND,        mfpc_pkg::CFG_DATA_W'(db));
    write_reg(mfpc_pkg::REG_TOUCH_ON_LEVEL,  mfpc_pkg::CFG_DATA_W'(on_lvl));
    write_reg(mfpc_pkg::REG_TOUCH_OFF_LEVEL, mfpc_pkg::CFG_DATA_W'(off_lvl));
    write_reg(mfpc_pkg::REG_RELEASE_HOLD_MS, mfpc_pkg::CFG_DATA_W'(hold));
    cfg_valid <= 1'b0;
  endtask

  // Random tick biased toward realistic use: the wiper mostly sits near the
  // current target so the speed bands and deadband get exercised, the hand is
  // mostly off, with touches, odd levels and full-range samples mixed in.
  function automatic mfpc_pkg::sample_t make_tick();
    mfpc_pkg::sample_t s;
    int                pick;
    int                p;
    pick = $urandom_range(99);
    if (pick < 55) begin
      p = int'(fc.target_pos) + int'($urandom_range(400)) - 200;
      if (p < 0) p = 0;
      if (p > 1023) p = 1023;
      s.position_sample = p[mfpc_pkg::ADC_BITS-1:0];
    end else begin
      s.position_sample = mfpc_pkg::ADC_BITS'($urandom_range(1023));
    end
    pick = $urandom_range(99);
    if (pick < 75)
      s.touch_level = (fc.touch_off == '0) ? '0 :
                      mfpc_pkg::LEVEL_BITS'($urandom_range(int'(fc.touch_off) - 1));
    else if (pick < 87)
      s.touch_level = mfpc_pkg::LEVEL_BITS'($urandom_range(65535, int'(fc.touch_on)));
    else
      s.touch_level = mfpc_pkg::LEVEL_BITS'($urandom_range(65535));
    s.elapsed_ms   = mfpc_pkg::MS_BITS'($urandom_range(1) ? $urandom_range(40) :
                                                            $urandom_range(1023));
    s.target_valid = ($urandom_range(3) == 0);
    s.target_midi  = mfpc_pkg::MIDI_BITS'($urandom_range(127));
    return s;
  endfunction

  initial begin
    fc           = new();
    gap_pct      = 0;
    stall_pct    = 0;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    result_ready = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = mfpc_pkg::REG_MIN_POSITION;
    cfg_data     = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset calibration: mapping extremes, start and running speed
    // bands, deadband edge, touch and release hysteresis, hold timer.
    tick(10'd0,    16'd0,     10'd0,    1'b1, 7'd0);
    tick(10'd1023, 16'd0,     10'd0,    1'b1, 7'd127);
    tick(10'd1023, 16'd0,     10'd0,    1'b1, 7'd0);    // far start, full speed down
    tick(10'd600,  16'd0,     10'd5,    1'b0, 7'd0);
    tick(10'd120,  16'd0,     10'd5,    1'b0, 7'd0);    // mid band
    tick(10'd60,   16'd0,     10'd5,    1'b0, 7'd0);    // proportional band
    tick(10'd8,    16'd0,     10'd5,    1'b0, 7'd0);    // error equals deadband, stop
    tick(10'd40,   16'd0,     10'd5,    1'b1, 7'd0);    // near start, reduced speed
    tick(10'd0,    16'd0,     10'd5,    1'b1, 7'd127);  // drive up
    tick(10'd500,  16'd65535, 10'd5,    1'b0, 7'd0);    // grab the knob
    tick(10'd500,  16'd100,   10'd5,    1'b1, 7'd64);   // target while held is dropped
    tick(10'd500,  16'd49,    10'd1023, 1'b0, 7'd0);    // release, time not counted
    tick(10'd500,  16'd0,     10'd500,  1'b0, 7'd0);    // hold not yet passed
    tick(10'd0,    16'd0,     10'd1,    1'b1, 7'd127);  // hold passed, resume
    tick(10'd0,    16'd150,   10'd1,    1'b0, 7'd0);    // exactly at the on level
    tick(10'd0,    16'd50,    10'd1,    1'b0, 7'd0);    // exactly at the off level
    tick(10'd0,    16'd49,    10'd1,    1'b0, 7'd0);

    // Equal limits: everything maps to zero.
    apply_setting(512, 512, 8, 150, 50, 500);
    tick(10'd0,    16'd0, 10'd1023, 1'b0, 7'd0);
    tick(10'd1023, 16'd0, 10'd0,    1'b1, 7'd100);

    // Crossed limits: min above max in ADC terms, so the range is inverted.
    apply_setting(900, 100, 8, 150, 50, 500);
    tick(10'd1023, 16'd0, 10'd0, 1'b0, 7'd0);
    tick(10'd50,   16'd0, 10'd0, 1'b1, 7'd127);
    tick(10'd700,  16'd0, 10'd0, 1'b1, 7'd1);
    tick(10'd0,    16'd0, 10'd0, 1'b0, 7'd0);

    // Random phases: each one recalibrates and picks its own handshake pressure.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_setting(0,    1023, 8,   150,   50,    500);
        1: apply_setting(0,    1023, 0,   65535, 65535, 0);
        2: apply_setting(100,  900,  255, 1000,  999,   1023);
        3: apply_setting(300,  300,  20,  150,   50,    10);
        4: apply_setting(800,  200,  4,   0,     1000,  100);
        5: apply_setting(0,    1023, 16,  300,   100,   50);
        6: apply_setting(1023, 0,    8,   150,   50,    500);
        default: apply_setting(0, 0, 255, 60000, 0, 1023);
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      for (int n = 0; n < 190; n++) begin
        // Hold the source mid-phase until the block has answered everything.
        if (phase == 2 && n == 95)
          drain();
        send_tick(make_tick());
      end
    end

    drain();
    stall_pct = 0;
    repeat (60) @(posedge clk);
    if (fc.mismatches == 0 && fc.motor_cmds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
